// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define CVB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define CVB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/cvb_pkg.sv -----
// Types and constants shared by the convolution, bias and ReLU block.
package cvb_pkg;

    // Kernel geometry and stored line count.
    localparam int KERNEL_SIZE = 5;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINES       = KERNEL_SIZE - 1;

    // Field widths.
    localparam int DATA_BITS   = 16;
    localparam int SLOT_W      = 5;
    localparam int FEAT_W      = 15;
    localparam int COORD_W     = 8;
    localparam int CFG_DIM_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Row count limit and arithmetic widths.
    localparam int ROW_LIMIT   = 256;
    localparam int WEIGHT_FRAC = 12;
    localparam int PROD_W      = 2 * DATA_BITS;
    localparam int ROW_SUM_W   = PROD_W + 3;
    localparam int ACC_W       = PROD_W + 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DIM_W-1:0] IMAGE_DIM_RESET = 9'd32;

    // What an input beat carries.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    // Position and frame marker of one result.
    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               last;
    } meta_t;

    // Command passed from the front end to the datapath.
    typedef struct packed {
        func_t                        kind;
        logic [SLOT_W-1:0]            slot;
        logic signed [DATA_BITS-1:0]  sample;
        logic                         emit;
        meta_t                        meta;
    } cmd_t;

endpackage

// ----- hdl/conv2d_valid_bias_relu.sv -----
// Top level of the 5x5 valid convolution with bias and ReLU over a pixel stream.
// The block takes one input beat per clock and gives at most one result per beat;
// with the output side ready it sustains one beat every cycle. A result enters the
// output register after its pixel beat passes the command queue, the line store
// read, at whose end the window shifts, then the 25 parallel multipliers, the row
// sums, the bias add and the ReLU/round/saturate stage. The single read port of
// each line store sets the one-beat-per-cycle pace. After reset the line stores
// are cleared, one column a cycle, over all MAX_WIDTH columns; s_tready stays low
// during that pass, while configuration writes are taken as ever. Weight load
// beats give no result. Stalls on m_tready hold the datapath, and the four-entry
// command queue keeps the input side moving until it fills.
module conv2d_valid_bias_relu #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: weight_slot [4:0], sample_value [20:5], zero fill [23:21].
    input  logic [cvb_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: func [0].
    input  logic                           s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: feature_value [14:0], out_row [22:15], out_col [30:23], zero fill [31].
    output logic [cvb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [cvb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import cvb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int Q_W = $bits(cmd_t) + CW;

    logic [CFG_DIM_W-1:0]        width_reg;
    logic [CFG_DIM_W-1:0]        height_reg;
    logic signed [DATA_BITS-1:0] bias_reg;

    logic              push;
    cmd_t              push_cmd;
    logic [CW-1:0]     push_col;
    logic              queue_full;
    logic              queue_empty;
    logic              pop;
    logic [Q_W-1:0]    head_data;
    cmd_t              head_cmd;
    logic [CW-1:0]     head_col;
    logic              clearing;
    logic [FEAT_W-1:0] feature_value;
    meta_t             m_meta;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= IMAGE_DIM_RESET;
            height_reg <= IMAGE_DIM_RESET;
            bias_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[CFG_DIM_W-1:0];
                CFG_BIAS_VALUE:   bias_reg   <= cfg_wdata[DATA_BITS-1:0];
                default: ;
            endcase
        end
    end

    cvb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .queue_full   (queue_full),
        .clearing     (clearing),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_col     (push_col)
    );

    cvb_queue #(
        .DATA_W (Q_W),
        .DEPTH  (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_col, push_cmd}),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head_data (head_data)
    );

    assign head_cmd = cmd_t'(head_data[$bits(cmd_t)-1:0]);
    assign head_col = head_data[Q_W-1:$bits(cmd_t)];

    cvb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .head_cmd      (head_cmd),
        .head_col      (head_col),
        .bias_value    (bias_reg),
        .clearing      (clearing),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .feature_value (feature_value),
        .m_meta        (m_meta)
    );

    // Result beat packing.
    assign m_tdata = {1'b0, m_meta.out_col, m_meta.out_row, feature_value};
    assign m_tlast = m_meta.last;

endmodule

// ----- hdl/cvb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module cvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cvb_queue.sv -----
// Short first-in first-out queue between the front end and the datapath.
module cvb_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] head_data
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = entry_reg[rd_ptr_reg];

    // Storage of the queued beats.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/cvb_front.sv -----
// Front end: accepts input beats, tracks the raster position and builds commands.
module cvb_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cvb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic [cvb_pkg::CFG_DIM_W-1:0] image_width,
    input  logic [cvb_pkg::CFG_DIM_W-1:0] image_height,
    input  logic                          queue_full,
    input  logic                          clearing,
    output logic                          push,
    output cvb_pkg::cmd_t                 push_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_col
);

    import cvb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;

    logic [CW-1:0]        column_reg;
    logic [CW-1:0]        column_next;
    logic [COORD_W-1:0]   row_reg;
    logic [COORD_W-1:0]   row_next;
    logic                 accept;
    func_t                func;
    logic [SLOT_W-1:0]    slot;
    logic [EW-1:0]        width_ext;
    logic [EW-1:0]        width_lim;
    logic [CFG_DIM_W-1:0] height_lim;
    logic [EW-1:0]        col_ext;
    logic [EW-1:0]        col_inc;
    logic [CFG_DIM_W-1:0] row_ext;
    logic [CFG_DIM_W-1:0] row_inc;
    logic                 is_pixel;

    assign s_tready = !queue_full && !clearing;
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign slot     = s_tdata[SLOT_W-1:0];
    assign is_pixel = (func == FUNC_PIXEL);

    // Clamp the frame size to what the line stores and row counter hold.
    always_comb begin
        width_ext = EW'(image_width);
        if (width_ext < EW'(KERNEL_SIZE)) begin
            width_lim = EW'(KERNEL_SIZE);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_lim = EW'(MAX_WIDTH);
        end else begin
            width_lim = width_ext;
        end
        if (image_height < CFG_DIM_W'(KERNEL_SIZE)) begin
            height_lim = CFG_DIM_W'(KERNEL_SIZE);
        end else if (image_height > CFG_DIM_W'(ROW_LIMIT)) begin
            height_lim = CFG_DIM_W'(ROW_LIMIT);
        end else begin
            height_lim = image_height;
        end
    end

    // Command for the datapath and the position of the next pixel.
    always_comb begin
        col_ext = EW'(column_reg);
        col_inc = col_ext + 1'b1;
        row_ext = CFG_DIM_W'(row_reg);
        row_inc = row_ext + 1'b1;

        push_cmd.kind          = func;
        push_cmd.slot          = slot;
        push_cmd.sample        = s_tdata[SLOT_W +: DATA_BITS];
        push_cmd.emit          = (row_ext >= CFG_DIM_W'(KERNEL_SIZE - 1)) &&
                                 (col_ext >= EW'(KERNEL_SIZE - 1));
        push_cmd.meta.out_row  = row_reg - COORD_W'(KERNEL_SIZE - 1);
        push_cmd.meta.out_col  = COORD_W'(col_ext - EW'(KERNEL_SIZE - 1));
        push_cmd.meta.last     = (row_ext == height_lim - 1'b1) &&
                                 (col_ext == width_lim - 1'b1);
        push_col               = column_reg;

        // Weight loads to a slot outside the kernel are dropped here.
        push = accept && (is_pixel || (slot < SLOT_W'(TAPS)));

        column_next = column_reg;
        row_next    = row_reg;
        if (accept && is_pixel) begin
            if (col_inc >= width_lim) begin
                column_next = '0;
                row_next    = (row_inc >= height_lim) ? '0 : COORD_W'(row_inc);
            end else begin
                column_next = CW'(col_inc);
            end
        end
    end

    // Raster position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ----- hdl/cvb_back.sv -----
// Datapath: line stores, sliding window, multiply-accumulate, bias, ReLU and output register.
module cvb_back #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 queue_empty,
    output logic                                 pop,
    input  cvb_pkg::cmd_t                        head_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]         head_col,
    input  logic signed [cvb_pkg::DATA_BITS-1:0] bias_value,
    output logic                                 clearing,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cvb_pkg::FEAT_W-1:0]           feature_value,
    output cvb_pkg::meta_t                       m_meta
);

    import cvb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Pipeline control.
    logic        adv;
    logic        clearing_reg;
    logic [CW-1:0] clr_addr_reg;

    // Stage registers.
    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [CW-1:0] s1_col_reg;
    logic        s2_valid_reg;
    meta_t       s2_meta_reg;
    logic        s3_valid_reg;
    meta_t       s3_meta_reg;
    logic        s4_valid_reg;
    meta_t       s4_meta_reg;
    logic        s5_valid_reg;
    meta_t       s5_meta_reg;
    logic        m_valid_reg;
    meta_t       m_meta_reg;
    logic [FEAT_W-1:0] feat_reg;

    // Window, kernel and arithmetic.
    logic signed [DATA_BITS-1:0] win_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [DATA_BITS-1:0] kern_reg [TAPS];
    logic signed [PROD_W-1:0]    prod_reg [TAPS];
    logic signed [ROW_SUM_W-1:0] row_sum_reg [KERNEL_SIZE];
    logic signed [ROW_SUM_W-1:0] row_sum_next [KERNEL_SIZE];
    logic signed [ACC_W-1:0]     total_reg;
    logic signed [ACC_W-1:0]     total_next;
    logic [ACC_W-1:0]            rounded;
    logic                        positive;
    logic                        overflow;
    logic [FEAT_W-1:0]           feat_next;

    // Line store ports.
    logic [DATA_BITS-1:0]        ram_rdata [LINES];
    logic signed [DATA_BITS-1:0] tap [KERNEL_SIZE];
    logic                        ram_we;
    logic [CW-1:0]               ram_waddr;
    logic                        s1_pixel;

    // The whole pipeline moves when the output register is free or being taken.
    assign adv      = !m_valid_reg || m_tready;
    assign pop      = adv && !queue_empty && !clearing_reg;
    assign clearing = clearing_reg;
    assign s1_pixel = s1_valid_reg && (s1_cmd_reg.kind == FUNC_PIXEL);

    // Clearing pass over the line stores after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Column of taps: older rows from the line stores, newest pixel on top.
    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            tap[i] = ram_rdata[i];
        end
        tap[LINES] = s1_cmd_reg.sample;
    end

    assign ram_we    = clearing_reg || (adv && s1_pixel);
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_col_reg;

    // Each line store moves its column up by one row.
    for (genvar g = 0; g < LINES; g++) begin : g_line
        logic [DATA_BITS-1:0] wdata;
        assign wdata = clearing_reg ? '0 : tap[g + 1];
        cvb_ram #(
            .WIDTH (DATA_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (aclk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (wdata),
            .re    (pop),
            .raddr (head_col),
            .rdata (ram_rdata[g])
        );
    end

    // Stage one holds the command while the line stores are read.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg <= head_cmd;
            s1_col_reg <= head_col;
        end
    end

    // Sliding window and kernel store, updated in command order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
            for (int t = 0; t < TAPS; t++) begin
                kern_reg[t] <= '0;
            end
        end else if (adv && s1_valid_reg) begin
            if (s1_cmd_reg.kind == FUNC_PIXEL) begin
                for (int r = 0; r < KERNEL_SIZE; r++) begin
                    for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                        win_reg[r][c] <= win_reg[r][c + 1];
                    end
                    win_reg[r][KERNEL_SIZE - 1] <= tap[r];
                end
            end else begin
                kern_reg[s1_cmd_reg.slot] <= s1_cmd_reg.sample;
            end
        end
    end

    // Products of window and kernel.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    prod_reg[r * KERNEL_SIZE + c] <=
                        win_reg[r][c] * kern_reg[r * KERNEL_SIZE + c];
                end
            end
        end
    end

    // One partial sum per kernel row.
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            row_sum_next[r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                row_sum_next[r] = row_sum_next[r] +
                                  ROW_SUM_W'(prod_reg[r * KERNEL_SIZE + c]);
            end
        end
    end

    // Row sums plus the bias scaled to the product format.
    always_comb begin
        total_next = ACC_W'(bias_value) <<< WEIGHT_FRAC;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            total_next = total_next + ACC_W'(row_sum_reg[r]);
        end
    end

    // ReLU, round half up to Q7.8 and saturate.
    always_comb begin
        rounded   = total_reg + ACC_W'(1 << (WEIGHT_FRAC - 1));
        positive  = !total_reg[ACC_W - 1] && (total_reg != '0);
        overflow  = |rounded[ACC_W-1:WEIGHT_FRAC + FEAT_W];
        if (!positive) begin
            feat_next = '0;
        end else if (overflow) begin
            feat_next = '1;
        end else begin
            feat_next = rounded[WEIGHT_FRAC + FEAT_W - 1:WEIGHT_FRAC];
        end
    end

    // Arithmetic payload stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                row_sum_reg[r] <= row_sum_next[r];
            end
            total_reg   <= total_next;
            feat_reg    <= feat_next;
            s2_meta_reg <= s1_cmd_reg.meta;
            s3_meta_reg <= s2_meta_reg;
            s4_meta_reg <= s3_meta_reg;
            s5_meta_reg <= s4_meta_reg;
            m_meta_reg  <= s5_meta_reg;
        end
    end

    // Stage valid bits; only pixels at a full window position go past stage one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_pixel && s1_cmd_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            m_valid_reg  <= s5_valid_reg;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign feature_value = feat_reg;
    assign m_meta        = m_meta_reg;

endmodule

// ----- hdl/cvb_checker.sv -----
// Port-level checker for the convolution block, bound to its top level.
`include "assert_macros.svh"

module cvb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cvb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import cvb_pkg::*;

    // A stalled result beat stays offered.
    `CVB_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

    // A stalled result beat keeps its payload.
    `CVB_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "result payload changed while stalled")

    // Reset empties the output register.
    `CVB_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // The line store clearing pass blocks input right after reset.
    `CVB_ASSERT_ALWAYS(a_clear_blocks, $rose(aresetn) |-> !s_tready, "input taken during line store clearing")

endmodule

bind conv2d_valid_bias_relu cvb_checker u_cvb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
